// ===== hdl/rtp_nal_depacketizer_macros.svh =====
// Assertion macros shared by the depacketizer RTL.
`ifndef RTP_NAL_DEPACKETIZER_MACROS_SVH
`define RTP_NAL_DEPACKETIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RND_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rnd assertion failed");

// Next-cycle implication, checked outside reset.
`define RND_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rnd assertion failed");

`endif

// ===== hdl/rnd_pkg.sv =====
// Shared types and constants for the RTP NAL depacketizer.
`timescale 1ns / 1ps
package rnd_pkg;

    localparam logic [5:0] TYPE_AGG  = 6'd48;
    localparam logic [5:0] TYPE_FRAG = 6'd49;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        POS_IDLE = 4'b0001,
        POS_B1   = 4'b0010,
        POS_B2   = 4'b0100,
        POS_BODY = 4'b1000
    } pos_t;

    typedef enum logic [2:0] {
        KIND_SINGLE = 3'b001,
        KIND_AGG    = 3'b010,
        KIND_FRAG   = 3'b100
    } kind_t;

    typedef enum logic [3:0] {
        AGG_LEN_HI = 4'b0001,
        AGG_LEN_LO = 4'b0010,
        AGG_FIRST  = 4'b0100,
        AGG_MORE   = 4'b1000
    } agg_phase_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        packet_first;
        logic        packet_last;
        logic [15:0] seq_number;
    } in_item_t;

    typedef struct packed {
        logic [7:0] nal_byte;
        logic       has_byte;
        logic       unit_start;
        logic       unit_end;
        logic       last_result;
    } result_t;

    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] res;
    } step_t;

    typedef struct packed {
        logic [2:0] level;
        logic       room;
    } queue_status_t;

endpackage

// ===== hdl/rnd_core.sv =====
// Packet parser state and per-beat result generation.
`timescale 1ns / 1ps
module rnd_core
    import rnd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output step_t    step
);

    logic [15:0] last_seq_reg, last_seq_next;
    logic        drop_reg, drop_next;
    pos_t        pos_reg, pos_next;
    logic [7:0]  held_first_reg, held_first_next;
    kind_t       kind_reg, kind_next;
    logic        open_reg, open_next;
    logic        frag_end_reg, frag_end_next;
    agg_phase_t  phase_reg, phase_next;
    logic [15:0] remain_reg, remain_next;
    logic [1:0]  held2_reg, held2_next;

    always_comb
    begin
        logic [7:0]    b;
        logic          lst;
        logic          ov;
        logic          endu;
        logic [1:0]    cnt;
        result_t [2:0] res;

        b   = item.payload_byte;
        lst = item.packet_last;
        cnt = 2'd0;
        res = '0;
        ov  = open_reg;
        endu = 1'b0;

        last_seq_next   = last_seq_reg;
        drop_next       = drop_reg;
        pos_next        = pos_reg;
        held_first_next = held_first_reg;
        kind_next       = kind_reg;
        open_next       = open_reg;
        frag_end_next   = frag_end_reg;
        phase_next      = phase_reg;
        remain_next     = remain_reg;
        held2_next      = held2_reg;

        if (item.packet_first)
        begin
            // close a unit cut short by the new packet
            if (pos_reg == POS_BODY && !drop_reg &&
                (kind_reg == KIND_SINGLE || (kind_reg == KIND_AGG && phase_reg == AGG_MORE)))
            begin
                res[cnt] = '{nal_byte: 8'h00, has_byte: 1'b0, unit_start: 1'b0,
                             unit_end: 1'b1, last_result: 1'b0};
                cnt = cnt + 2'd1;
            end
            if (item.seq_number < last_seq_reg)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                drop_next     = 1'b0;
                last_seq_next = item.seq_number;
            end
            held_first_next = b;
            kind_next       = KIND_SINGLE;
            phase_next      = AGG_LEN_HI;
            remain_next     = 16'd0;
            frag_end_next   = 1'b0;
            pos_next        = lst ? POS_IDLE : POS_B1;
        end
        else if (pos_reg == POS_IDLE)
        begin
            // stray byte outside a packet: drop
        end
        else if (drop_reg)
        begin
            if (lst)
            begin
                pos_next = POS_IDLE;
            end
        end
        else
        begin
            case (pos_reg)
                POS_B1:
                begin
                    if (b[5:0] == TYPE_FRAG)
                    begin
                        kind_next  = KIND_FRAG;
                        held2_next = b[7:6];
                        pos_next   = lst ? POS_IDLE : POS_B2;
                    end
                    else
                    begin
                        if (open_reg)
                        begin
                            res[cnt] = '{nal_byte: 8'h00, has_byte: 1'b0, unit_start: 1'b0,
                                         unit_end: 1'b1, last_result: 1'b0};
                            cnt = cnt + 2'd1;
                            open_next = 1'b0;
                        end
                        if (b[5:0] == TYPE_AGG)
                        begin
                            kind_next  = KIND_AGG;
                            phase_next = AGG_LEN_HI;
                        end
                        else
                        begin
                            kind_next = KIND_SINGLE;
                            res[cnt] = '{nal_byte: held_first_reg, has_byte: 1'b1,
                                         unit_start: 1'b1, unit_end: 1'b0, last_result: 1'b0};
                            cnt = cnt + 2'd1;
                            res[cnt] = '{nal_byte: b, has_byte: 1'b1, unit_start: 1'b0,
                                         unit_end: lst, last_result: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                        pos_next = lst ? POS_IDLE : POS_BODY;
                    end
                end
                POS_B2:
                begin
                    // FU header: bit 7 start, bit 6 end
                    if (b[7] && ov)
                    begin
                        res[cnt] = '{nal_byte: 8'h00, has_byte: 1'b0, unit_start: 1'b0,
                                     unit_end: 1'b1, last_result: 1'b0};
                        cnt = cnt + 2'd1;
                        ov = 1'b0;
                    end
                    if (!ov)
                    begin
                        res[cnt] = '{nal_byte: held_first_reg, has_byte: 1'b1,
                                     unit_start: 1'b1, unit_end: 1'b0, last_result: 1'b0};
                        cnt = cnt + 2'd1;
                        res[cnt] = '{nal_byte: {held2_reg, b[5:0]}, has_byte: 1'b1,
                                     unit_start: 1'b0, unit_end: lst & b[6],
                                     last_result: 1'b0};
                        cnt = cnt + 2'd1;
                        ov = 1'b1;
                    end
                    else if (lst && b[6])
                    begin
                        res[cnt] = '{nal_byte: 8'h00, has_byte: 1'b0, unit_start: 1'b0,
                                     unit_end: 1'b1, last_result: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                    if (lst && b[6])
                    begin
                        ov = 1'b0;
                    end
                    open_next     = ov;
                    frag_end_next = b[6];
                    pos_next      = lst ? POS_IDLE : POS_BODY;
                end
                POS_BODY:
                begin
                    case (kind_reg)
                        KIND_AGG:
                        begin
                            case (phase_reg)
                                AGG_LEN_HI:
                                begin
                                    remain_next = {b, 8'h00};
                                    phase_next  = AGG_LEN_LO;
                                end
                                AGG_LEN_LO:
                                begin
                                    remain_next = remain_reg | {8'h00, b};
                                    phase_next  = (remain_next != 16'd0) ? AGG_FIRST : AGG_LEN_HI;
                                end
                                default:
                                begin
                                    endu = lst || (remain_reg <= 16'd1);
                                    res[cnt] = '{nal_byte: b, has_byte: 1'b1,
                                                 unit_start: (phase_reg == AGG_FIRST),
                                                 unit_end: endu, last_result: 1'b0};
                                    cnt = cnt + 2'd1;
                                    remain_next = remain_reg - 16'd1;
                                    phase_next  = (remain_next != 16'd0) ? AGG_MORE : AGG_LEN_HI;
                                end
                            endcase
                        end
                        KIND_FRAG:
                        begin
                            res[cnt] = '{nal_byte: b, has_byte: 1'b1, unit_start: 1'b0,
                                         unit_end: lst & frag_end_reg, last_result: 1'b0};
                            cnt = cnt + 2'd1;
                            if (lst && frag_end_reg)
                            begin
                                open_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            res[cnt] = '{nal_byte: b, has_byte: 1'b1, unit_start: 1'b0,
                                         unit_end: lst, last_result: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    endcase
                    if (lst)
                    begin
                        pos_next = POS_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cnt != 2'd0)
        begin
            res[cnt - 2'd1].last_result = 1'b1;
        end
        step.count = cnt;
        step.res   = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg   <= 16'd0;
            drop_reg       <= 1'b0;
            pos_reg        <= POS_IDLE;
            held_first_reg <= 8'h00;
            kind_reg       <= KIND_SINGLE;
            open_reg       <= 1'b0;
            frag_end_reg   <= 1'b0;
            phase_reg      <= AGG_LEN_HI;
            remain_reg     <= 16'd0;
            held2_reg      <= 2'b00;
        end
        else if (accept)
        begin
            last_seq_reg   <= last_seq_next;
            drop_reg       <= drop_next;
            pos_reg        <= pos_next;
            held_first_reg <= held_first_next;
            kind_reg       <= kind_next;
            open_reg       <= open_next;
            frag_end_reg   <= frag_end_next;
            phase_reg      <= phase_next;
            remain_reg     <= remain_next;
            held2_reg      <= held2_next;
        end
    end

endmodule

// ===== hdl/rnd_out_queue.sv =====
// Result queue: takes up to three results per beat, drains one per cycle while out_ready is high.
`timescale 1ns / 1ps
module rnd_out_queue
    import rnd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  step_t         step,
    input  logic          out_ready,
    output logic          out_valid,
    output result_t       head,
    output queue_status_t status
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    result_t        q_reg [QUEUE_DEPTH];
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW:0]    level_reg, level_next;
    logic           pop;
    logic [1:0]     push_cnt;

    assign out_valid = (level_reg != '0);
    assign pop       = out_valid && out_ready;
    assign push_cnt  = push ? step.count : 2'd0;
    assign head      = q_reg[rptr_reg];

    // keep room for a full burst of results after this cycle's drain
    assign status.room  = (level_reg <= (PW+1)'(QUEUE_DEPTH - MAX_RESULTS)) ||
                          ((level_reg == (PW+1)'(QUEUE_DEPTH - MAX_RESULTS + 1)) && pop);
    assign status.level = 3'(level_reg);

    assign rptr_next  = rptr_reg + PW'(pop);
    assign wptr_next  = wptr_reg + PW'(push_cnt);
    assign level_next = level_reg - (PW+1)'(pop) + (PW+1)'(push_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (push && (2'(i) < step.count))
            begin
                q_reg[wptr_reg + PW'(i)] <= step.res[i];
            end
        end
    end

endmodule

// ===== hdl/rtp_nal_depacketizer.sv =====
// Top level of the RTP NAL unit depacketizer.
//
//  channel | direction | payload                                         | handshake
//  input   | in        | payload_byte packet_first packet_last seq_number | in_valid/in_ready
//  output  | out       | nal_byte has_byte unit_start unit_end last_result | out_valid/out_ready
//
// Each input beat is parsed in the cycle it is accepted and yields zero to three results.
// Results sit in a four-entry queue and leave one per cycle while out_ready is high; the drain rate sets throughput.
// in_ready is high while the queue, after this cycle's drain, has room for three results.
// Reset clears parser state and empties the queue; no clearing pass is needed.
// An output stall holds the head result; input stalls only when the queue is too full.
`timescale 1ns / 1ps
`include "rtp_nal_depacketizer_macros.svh"
module rtp_nal_depacketizer
    import rnd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  payload_byte,
    input  logic        packet_first,
    input  logic        packet_last,
    input  logic [15:0] seq_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  nal_byte,
    output logic        has_byte,
    output logic        unit_start,
    output logic        unit_end,
    output logic        last_result
);

    in_item_t      item;
    step_t         step;
    result_t       head;
    queue_status_t status;
    logic          accept;

    assign item = '{payload_byte: payload_byte, packet_first: packet_first,
                    packet_last: packet_last, seq_number: seq_number};

    assign in_ready = status.room;
    assign accept   = in_valid && in_ready;

    rnd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .step   (step)
    );

    rnd_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .step      (step),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .status    (status)
    );

    assign nal_byte    = head.nal_byte;
    assign has_byte    = head.has_byte;
    assign unit_start  = head.unit_start;
    assign unit_end    = head.unit_end;
    assign last_result = head.last_result;

    `RND_ASSERT_NOW(a_empty_takes_beat, !out_valid, in_ready)
    `RND_ASSERT_NOW(a_level_in_range, 1'b1, status.level <= 3'(QUEUE_DEPTH))
    `RND_ASSERT_NEXT(a_stall_holds_head, out_valid && !out_ready,
                     out_valid && $stable(nal_byte) && $stable(last_result))

endmodule
